// ===== design/imu_sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_sdq_pkg
// Shared types and constants of the inertial sample queue: ring geometry,
// the stored sample layout and the fixed-point scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_sdq_pkg;

  // Ring geometry: one slot stays empty, so the ring holds QUEUE_DEPTH-1 samples
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  // Item codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int ACCEL_W = 20;
  localparam int FIX_W   = 26;

  // Acceleration: raw/4096 with 16 fractional bits is raw * 16
  localparam int ACCEL_SHIFT = 4;

  // Temperature: round(raw * 102400 / 207) + 25.0 in signed 10.16
  localparam int TEMP_NUM    = 102400;
  localparam int TEMP_DEN    = 207;
  localparam int TEMP_OFFSET = 1638400;

  // Rotation: round(raw * 131072 / 131)
  localparam int GYRO_NUM = 131072;
  localparam int GYRO_DEN = 131;

  // Shared multiplier geometry
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 26;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int RECIP_SHIFT = 33;

  // Reciprocals floor(2^33 / den); the estimate is low by at most one
  localparam logic [MUL_B_W-1:0] TEMP_RECIP =
    MUL_B_W'((64'd1 << RECIP_SHIFT) / TEMP_DEN);
  localparam logic [MUL_B_W-1:0] GYRO_RECIP =
    MUL_B_W'((64'd1 << RECIP_SHIFT) / GYRO_DEN);

  // Rounding bias (den-1)/2 for odd divisors
  localparam logic [MUL_A_W-1:0] TEMP_HALF = MUL_A_W'(TEMP_DEN / 2);
  localparam logic [MUL_A_W-1:0] GYRO_HALF = MUL_A_W'(GYRO_DEN / 2);

  // One stored sample
  typedef struct packed {
    logic [TIME_W-1:0]  time_us;
    logic [RAW_W-1:0]   temp;
    logic [3*RAW_W-1:0] accel;
    logic [3*RAW_W-1:0] gyro;
  } sample_t;

endpackage

`default_nettype wire

// ===== design/imu_sdq_store.sv =====
// ----------------------------------------------------------------------------
// imu_sdq_store
// Sample ring storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sdq_store (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [imu_sdq_pkg::IDX_W-1:0] wr_addr,
  input  wire imu_sdq_pkg::sample_t        wr_data,
  input  wire logic                        rd_en,
  input  wire logic [imu_sdq_pkg::IDX_W-1:0] rd_addr,
  output imu_sdq_pkg::sample_t             rd_data
);
  import imu_sdq_pkg::*;

  sample_t mem [QUEUE_DEPTH];

  // Write a new sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the oldest sample; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_sdq_scaler.sv =====
// ----------------------------------------------------------------------------
// imu_sdq_scaler
// Converts the temperature word and three rotation words to signed 10.16 fixed
// point, one after another, on a single registered multiplier: raw * num,
// then a reciprocal estimate of the quotient, then a remainder check.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sdq_scaler (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [imu_sdq_pkg::RAW_W-1:0]         temp_raw,
  input  wire logic [3*imu_sdq_pkg::RAW_W-1:0]       gyro_raw,
  output logic                                       done,
  output logic signed [imu_sdq_pkg::FIX_W-1:0]       temp_fixed,
  output logic signed [2:0][imu_sdq_pkg::FIX_W-1:0]  gyro_fixed
);
  import imu_sdq_pkg::*;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL_N,
    SC_MUL_R,
    SC_MUL_D,
    SC_FIX
  } sc_state_t;

  sc_state_t                 state;
  logic [1:0]                ch;
  logic [3:0][RAW_W-1:0]     raw_word;
  logic [PROD_W-1:0]         prod;
  logic [MUL_A_W-1:0]        p_reg;
  logic [MUL_B_W-1:0]        q0_reg;

  logic [RAW_W-1:0]          cur_raw;
  logic                      neg;
  logic [RAW_W-1:0]          mag;
  logic                      is_temp;
  logic [MUL_B_W-1:0]        k_num;
  logic [MUL_B_W-1:0]        k_recip;
  logic [MUL_A_W-1:0]        k_half;
  logic [MUL_A_W-1:0]        k_den;
  logic [MUL_A_W-1:0]        p_sum;
  logic [MUL_A_W-1:0]        rem;
  logic [MUL_B_W-1:0]        q_fin;
  logic [FIX_W-1:0]          s_val;
  logic [FIX_W-1:0]          res_val;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;

  // Select the current word and its constants
  always_comb begin
    cur_raw = raw_word[ch];
    neg     = cur_raw[RAW_W-1];
    mag     = neg ? RAW_W'(-cur_raw) : cur_raw;
    is_temp = (ch == 2'd0);
    k_num   = is_temp ? MUL_B_W'(TEMP_NUM) : MUL_B_W'(GYRO_NUM);
    k_recip = is_temp ? TEMP_RECIP : GYRO_RECIP;
    k_half  = is_temp ? TEMP_HALF : GYRO_HALF;
    k_den   = is_temp ? MUL_A_W'(TEMP_DEN) : MUL_A_W'(GYRO_DEN);
  end

  // Rounded dividend, remainder and corrected quotient
  always_comb begin
    p_sum   = prod[MUL_A_W-1:0] + k_half;
    rem     = p_reg - prod[MUL_A_W-1:0];
    q_fin   = q0_reg + MUL_B_W'(rem >= k_den);
    s_val   = neg ? FIX_W'(-q_fin) : FIX_W'(q_fin);
    res_val = is_temp ? (s_val + FIX_W'(TEMP_OFFSET)) : s_val;
  end

  // Steer the shared multiplier
  always_comb begin
    case (state)
      SC_MUL_N: begin
        mul_a = MUL_A_W'(mag);
        mul_b = k_num;
      end
      SC_MUL_R: begin
        mul_a = p_sum;
        mul_b = k_recip;
      end
      SC_MUL_D: begin
        mul_a = MUL_A_W'(prod[PROD_W-1:RECIP_SHIFT]);
        mul_b = MUL_B_W'(k_den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign done = (state == SC_FIX) && (ch == 2'd3);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      ch    <= '0;
    end else begin
      case (state)
        SC_IDLE: begin
          if (start) begin
            raw_word <= {gyro_raw, temp_raw};
            ch       <= '0;
            state    <= SC_MUL_N;
          end
        end
        SC_MUL_N: begin
          state <= SC_MUL_R;
        end
        SC_MUL_R: begin
          p_reg <= p_sum;
          state <= SC_MUL_D;
        end
        SC_MUL_D: begin
          q0_reg <= prod[PROD_W-1:RECIP_SHIFT];
          state  <= SC_FIX;
        end
        SC_FIX: begin
          if (is_temp) begin
            temp_fixed <= res_val;
          end else begin
            gyro_fixed[ch - 2'd1] <= res_val;
          end
          if (ch == 2'd3) begin
            state <= SC_IDLE;
          end else begin
            ch    <= ch + 2'd1;
            state <= SC_MUL_N;
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_sample_decode_queue_core.sv =====
// ----------------------------------------------------------------------------
// imu_sample_decode_queue_core
// Queue of inertial sensor samples that drops the newest sample when full,
// with fixed-point conversion of each sample as it leaves.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): mode 0 pushes the sample on the
//   payload, mode 1 pops the oldest one. A push into a full ring (one slot
//   short of the depth) is refused and counted as an overrun.
//   Output channel (out_valid / out_stall): exactly one result per input
//   transfer, carrying popped/dropped flags, the scaled sample and both
//   running counters after that item.
//   Timing: a push or a pop of an empty ring passes through the emit state
//   before the next input transfer. A pop that returns a sample takes one
//   storage read, then four results (temperature and three rotation axes)
//   of four steps each on the one shared multiplier.
//   in_stall stays high from an input transfer until its result is loaded
//   into the output register; the next item is taken while that result
//   still waits. If the receiver stalls and the output register is full,
//   the finished result holds in the block and the input stays stalled.
//   Reset empties the ring and clears both counters; storage contents are
//   not cleared, and only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_decode_queue_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 mode,
  input  wire logic [31:0]                          time_us,
  input  wire logic signed [15:0]                   temp_raw,
  input  wire logic signed [15:0]                   accel_x_raw,
  input  wire logic signed [15:0]                   accel_y_raw,
  input  wire logic signed [15:0]                   accel_z_raw,
  input  wire logic signed [15:0]                   gyro_x_raw,
  input  wire logic signed [15:0]                   gyro_y_raw,
  input  wire logic signed [15:0]                   gyro_z_raw,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      popped,
  output logic                                      dropped,
  output logic [31:0]                               sample_time,
  output logic signed [25:0]                        temp_c_fixed,
  output logic signed [19:0]                        accel_x_g,
  output logic signed [19:0]                        accel_y_g,
  output logic signed [19:0]                        accel_z_g,
  output logic signed [25:0]                        gyro_x_dps,
  output logic signed [25:0]                        gyro_y_dps,
  output logic signed [25:0]                        gyro_z_dps,
  output logic [31:0]                               stored_total,
  output logic [31:0]                               overrun_total
);
  import imu_sdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [IDX_W-1:0]               wr_idx;
  logic [IDX_W-1:0]               rd_idx;
  logic [CNT_W-1:0]               accepted_count;
  logic [CNT_W-1:0]               overrun_count;
  logic                           res_popped;
  logic                           res_dropped;

  logic                           in_xfer;
  logic                           is_pop;
  logic [IDX_W-1:0]               wr_idx_next;
  logic [IDX_W-1:0]               rd_idx_next;
  logic                           full;
  logic                           empty;
  logic                           emit_ok;
  logic                           st_wr_en;
  logic                           st_rd_en;
  sample_t                        wr_sample;
  sample_t                        rd_sample;
  logic                           sc_done;
  logic signed [FIX_W-1:0]        sc_temp;
  logic signed [2:0][FIX_W-1:0]   sc_gyro;

  // Handshake and ring status
  always_comb begin
    in_stall    = (state != ST_IDLE);
    in_xfer     = in_valid && !in_stall;
    is_pop      = (mode == MODE_POP);
    wr_idx_next = (wr_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
    rd_idx_next = (rd_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
    full        = (wr_idx_next == rd_idx);
    empty       = (wr_idx == rd_idx);
    emit_ok     = !out_valid || !out_stall;
    st_wr_en    = in_xfer && !is_pop && !full;
    st_rd_en    = in_xfer && is_pop && !empty;
  end

  // Pack the pushed sample
  always_comb begin
    wr_sample.time_us = time_us;
    wr_sample.temp    = temp_raw;
    wr_sample.accel   = {accel_z_raw, accel_y_raw, accel_x_raw};
    wr_sample.gyro    = {gyro_z_raw, gyro_y_raw, gyro_x_raw};
  end

  imu_sdq_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_sample),
    .rd_en   (st_rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_sample)
  );

  imu_sdq_scaler u_scaler (
    .clk        (clk),
    .rst        (rst),
    .start      (state == ST_READ),
    .temp_raw   (rd_sample.temp),
    .gyro_raw   (rd_sample.gyro),
    .done       (sc_done),
    .temp_fixed (sc_temp),
    .gyro_fixed (sc_gyro)
  );

  // Control sequence, ring indexes, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      wr_idx         <= '0;
      rd_idx         <= '0;
      accepted_count <= '0;
      overrun_count  <= '0;
      out_valid      <= 1'b0;
    end else begin
      // Drop the output once it has been transferred, unless a new one loads
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            res_dropped <= !is_pop && full;
            res_popped  <= is_pop && !empty;
            if (!is_pop) begin
              state <= ST_EMIT;
              if (full) begin
                overrun_count <= overrun_count + 1'b1;
              end else begin
                wr_idx         <= wr_idx_next;
                accepted_count <= accepted_count + 1'b1;
              end
            end else if (!empty) begin
              rd_idx <= rd_idx_next;
              state  <= ST_READ;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_READ: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          if (sc_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid     <= 1'b1;
            popped        <= res_popped;
            dropped       <= res_dropped;
            stored_total  <= accepted_count;
            overrun_total <= overrun_count;
            if (res_popped) begin
              sample_time  <= rd_sample.time_us;
              temp_c_fixed <= sc_temp;
              accel_x_g    <= ACCEL_W'({rd_sample.accel[RAW_W-1:0],
                                        {ACCEL_SHIFT{1'b0}}});
              accel_y_g    <= ACCEL_W'({rd_sample.accel[2*RAW_W-1:RAW_W],
                                        {ACCEL_SHIFT{1'b0}}});
              accel_z_g    <= ACCEL_W'({rd_sample.accel[3*RAW_W-1:2*RAW_W],
                                        {ACCEL_SHIFT{1'b0}}});
              gyro_x_dps   <= sc_gyro[0];
              gyro_y_dps   <= sc_gyro[1];
              gyro_z_dps   <= sc_gyro[2];
            end else begin
              sample_time  <= '0;
              temp_c_fixed <= '0;
              accel_x_g    <= '0;
              accel_y_g    <= '0;
              accel_z_g    <= '0;
              gyro_x_dps   <= '0;
              gyro_y_dps   <= '0;
              gyro_z_dps   <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
